### sv/timed_slot_table_defines.svh
// assertion helpers used by the timed slot table controller
`ifndef TIMED_SLOT_TABLE_DEFINES_SVH
`define TIMED_SLOT_TABLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TST_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/tst_pkg.sv
`timescale 1ns / 1ps
package tst_pkg;

	localparam int SLOT_COUNT_DEF = 4;

	localparam int FUNC_W  = 2;
	localparam int KIND_W  = 3;
	localparam int CLASS_W = 4;
	localparam int IDENT_W = 8;
	localparam int TIME_W  = 16;
	localparam int CFG_IDX_W = 2;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 8;

	localparam logic [FUNC_W-1:0] OP_EMIT  = 2'd0;
	localparam logic [FUNC_W-1:0] OP_TICK  = 2'd1;
	localparam logic [FUNC_W-1:0] OP_QUERY = 2'd2;
	localparam logic [FUNC_W-1:0] OP_NONE  = 2'd3;

	localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd3;

	localparam logic [CFG_IDX_W-1:0] REG_DUR_NORMAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUR_LONG   = 2'd1;

	localparam logic [TIME_W-1:0] DUR_NORMAL_RST = 16'd300;
	localparam logic [TIME_W-1:0] DUR_LONG_RST   = 16'd1000;

	typedef struct packed {
		logic              load;
		logic              scan;
		logic              write_pick;
		logic              push;
		logic [FUNC_W-1:0] op;
	} tst_cmd_t;

	typedef struct packed {
		logic stop;
		logic out_free;
	} tst_sts_t;

endpackage

### sv/timed_slot_table.sv
`timescale 1ns / 1ps
// channel  | signals                          | beat carries
// ---------+----------------------------------+-------------------------------------
// s        | s_tvalid s_tready s_tdata s_tuser | one command: emit, tick or query
// m        | m_tvalid m_tready m_tdata m_tuser | one query answer
// cfg      | cfg_valid cfg_ready cfg_index ... | one register write, always taken
//
// one slot is examined per cycle in the slot register file; that scan sets the cost.
// emit and query stop at a match (emit also at a free slot); tick scans all; query waits on output stall.
// an unused func code is taken and gives no answer.
// reset clears all timers at once, so every slot is free with no clearing pass.
// a waiting answer on m holds the block only once the next answer is ready to leave.
module timed_slot_table import tst_pkg::*; #(
	parameter int SlotCount = SLOT_COUNT_DEF,
	localparam int IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// kind[2:0], target_class[6:3], target_id[14:7], elapsed[30:15], zero[31]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// func[1:0]
	input  logic [FUNC_W-1:0]    s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// found_kind[2:0], zero[7:3]
	output logic [M_TDATA_W-1:0] m_tdata,
	// found[0]
	output logic                 m_tuser,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TIME_W-1:0]    cfg_data
);

	tst_cmd_t          cmd;
	tst_sts_t          sts;
	logic [IdxW-1:0]   idx;
	logic              out_found;
	logic [KIND_W-1:0] out_kind;

	assign cfg_ready = 1'b1;

	tst_ctrl #(
		.SlotCount(SlotCount)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (s_tuser),
		.sts      (sts),
		.cmd      (cmd),
		.idx      (idx)
	);

	tst_dp #(
		.SlotCount(SlotCount)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.idx        (idx),
		.sts        (sts),
		.cfg_we     (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_kind    (s_tdata[2:0]),
		.in_class   (s_tdata[6:3]),
		.in_ident   (s_tdata[14:7]),
		.in_elapsed (s_tdata[30:15]),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_found  (out_found),
		.out_kind   (out_kind)
	);

	assign m_tdata = {{(M_TDATA_W-KIND_W){1'b0}}, out_kind};
	assign m_tuser = out_found;

endmodule

### sv/tst_ctrl.sv
`timescale 1ns / 1ps
`include "timed_slot_table_defines.svh"
module tst_ctrl import tst_pkg::*; #(
	parameter int SlotCount = SLOT_COUNT_DEF,
	localparam int IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] in_func,
	input  tst_sts_t          sts,
	output tst_cmd_t          cmd,
	output logic [IdxW-1:0]   idx
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_WRITE  = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	localparam logic [IdxW-1:0] LastIdx = IdxW'(SlotCount - 1);

	logic [1:0]        state_q, state_n;
	logic [FUNC_W-1:0] op_q, op_n;
	logic [IdxW-1:0]   idx_q, idx_n;
	logic              last;

	assign last     = (idx_q == LastIdx);
	assign in_ready = (state_q == ST_IDLE);
	assign idx      = idx_q;

	always_comb begin
		state_n = state_q;
		op_n    = op_q;
		idx_n   = idx_q;
		cmd     = '0;
		cmd.op  = op_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					op_n     = in_func;
					idx_n    = '0;
					state_n  = (in_func == OP_NONE) ? ST_IDLE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.stop || last) begin
					case (op_q)
						OP_EMIT:  state_n = sts.stop ? ST_IDLE : ST_WRITE;
						OP_QUERY: state_n = ST_RESULT;
						default:  state_n = ST_IDLE;
					endcase
				end else begin
					idx_n = idx_q + 1'b1;
				end
			end
			ST_WRITE: begin
				// no free slot and no match: overwrite the weakest live slot
				cmd.write_pick = 1'b1;
				state_n        = ST_IDLE;
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_NONE;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			op_q    <= op_n;
			idx_q   <= idx_n;
		end
	end

	`TST_ASSERT_NOW(a_idx_range, state_q == ST_SCAN, idx_q <= LastIdx, "scan index out of range")
	`TST_ASSERT_NOW(a_push_query, cmd.push, op_q == OP_QUERY, "result pushed for non-query")
	`TST_ASSERT_NXT(a_write_ends, state_q == ST_WRITE, state_q == ST_IDLE, "write did not end item")
	`TST_ASSERT_NOW(a_write_emit, state_q == ST_WRITE, op_q == OP_EMIT, "eviction outside emit")

endmodule

### sv/tst_dp.sv
`timescale 1ns / 1ps
module tst_dp import tst_pkg::*; #(
	parameter int SlotCount = SLOT_COUNT_DEF,
	localparam int IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  tst_cmd_t                  cmd,
	input  logic [IdxW-1:0]           idx,
	output tst_sts_t                  sts,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [TIME_W-1:0]         cfg_data,
	input  logic [KIND_W-1:0]         in_kind,
	input  logic [CLASS_W-1:0]        in_class,
	input  logic signed [IDENT_W-1:0] in_ident,
	input  logic [TIME_W-1:0]         in_elapsed,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      out_found,
	output logic [KIND_W-1:0]         out_kind
);

	logic [TIME_W-1:0] dur_normal_q, dur_long_q;

	logic [KIND_W-1:0]         kind_q;
	logic [CLASS_W-1:0]        class_q;
	logic signed [IDENT_W-1:0] ident_q;
	logic [TIME_W-1:0]         elapsed_q;

	logic [KIND_W-1:0]         slot_kind_q  [SlotCount];
	logic [CLASS_W-1:0]        slot_class_q [SlotCount];
	logic signed [IDENT_W-1:0] slot_ident_q [SlotCount];
	logic [TIME_W-1:0]         slot_time_q  [SlotCount];

	logic [IdxW-1:0]   best_idx_q;
	logic [TIME_W-1:0] best_time_q;

	logic              res_found_q;
	logic [KIND_W-1:0] res_kind_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic [KIND_W-1:0] out_kind_q;

	logic [TIME_W-1:0] rd_time, life, tick_time;
	logic              live, emit_hit, query_hit, is_emit, is_query, is_tick;

	assign is_emit  = (cmd.op == OP_EMIT);
	assign is_tick  = (cmd.op == OP_TICK);
	assign is_query = (cmd.op == OP_QUERY);

	assign rd_time  = slot_time_q[idx];
	assign live     = (rd_time != '0);
	assign emit_hit = live && (slot_kind_q[idx] == kind_q) && (slot_class_q[idx] == class_q)
		&& (slot_ident_q[idx] == ident_q);
	// a negative stored id is a wildcard for any query id
	assign query_hit = live && (slot_class_q[idx] == class_q)
		&& (slot_ident_q[idx][IDENT_W-1] || (slot_ident_q[idx] == ident_q));
	assign life      = (kind_q == KIND_CLEAR_ALL) ? dur_long_q : dur_normal_q;
	assign tick_time = (rd_time > elapsed_q) ? (rd_time - elapsed_q) : '0;

	always_comb begin
		sts          = '0;
		sts.out_free = !out_valid_q || out_ready;
		case (cmd.op)
			OP_EMIT:  sts.stop = emit_hit || !live;
			OP_QUERY: sts.stop = query_hit;
			default:  sts.stop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_normal_q <= DUR_NORMAL_RST;
			dur_long_q   <= DUR_LONG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DUR_NORMAL: dur_normal_q <= cfg_data;
				REG_DUR_LONG:   dur_long_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= in_kind;
			class_q   <= in_class;
			ident_q   <= in_ident;
			elapsed_q <= in_elapsed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SlotCount; i++) begin
				slot_time_q[i] <= '0;
			end
		end else if (cmd.scan) begin
			if (is_emit && (emit_hit || !live)) begin
				slot_time_q[idx] <= life;
			end else if (is_tick) begin
				slot_time_q[idx] <= tick_time;
			end
		end else if (cmd.write_pick) begin
			slot_time_q[best_idx_q] <= life;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan && is_emit && !live) begin
			slot_kind_q[idx]  <= kind_q;
			slot_class_q[idx] <= class_q;
			slot_ident_q[idx] <= ident_q;
		end else if (cmd.write_pick) begin
			slot_kind_q[best_idx_q]  <= kind_q;
			slot_class_q[best_idx_q] <= class_q;
			slot_ident_q[best_idx_q] <= ident_q;
		end
	end

	// least time left among live slots, earliest on ties
	always_ff @(posedge clk) begin
		if (cmd.scan && is_emit && live && !emit_hit) begin
			if ((idx == '0) || (rd_time < best_time_q)) begin
				best_idx_q  <= idx;
				best_time_q <= rd_time;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_found_q <= 1'b0;
			res_kind_q  <= '0;
		end else if (cmd.scan && is_query && query_hit) begin
			res_found_q <= 1'b1;
			res_kind_q  <= slot_kind_q[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_found_q <= res_found_q;
			out_kind_q  <= res_kind_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_kind  = out_kind_q;

endmodule

### dv/timed_slot_table_test.sv
`timescale 1ns / 1ps
module timed_slot_table_test;
	import tst_pkg::*;

	localparam int SLOTS          = SLOT_COUNT_DEF;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 7;
	localparam int REPORT_CAP     = 50;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct {
		logic [FUNC_W-1:0]         op;
		logic [KIND_W-1:0]         kind;
		logic [CLASS_W-1:0]        cls;
		logic signed [IDENT_W-1:0] ident;
		logic [TIME_W-1:0]         elapsed;
	} command_t;

	typedef struct packed {
		logic              found;
		logic [KIND_W-1:0] kind;
	} answer_t;

	class slot_table_scoreboard;
		logic [TIME_W-1:0]  dur_normal;
		logic [TIME_W-1:0]  dur_long;
		logic [KIND_W-1:0]  entry_kind  [SLOTS];
		logic [CLASS_W-1:0] entry_class [SLOTS];
		logic [IDENT_W-1:0] entry_ident [SLOTS];
		logic [TIME_W-1:0]  time_left   [SLOTS];
		answer_t pending_answers[$];

		function new();
			dur_normal = DUR_NORMAL_RST;
			dur_long   = DUR_LONG_RST;
			for (int i = 0; i < SLOTS; i++) begin
				entry_kind[i]  = '0;
				entry_class[i] = '0;
				entry_ident[i] = '0;
				time_left[i]   = '0;
			end
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
			if (idx == REG_DUR_NORMAL) begin
				dur_normal = val;
			end else if (idx == REG_DUR_LONG) begin
				dur_long = val;
			end
		endfunction

		function void note_command(command_t c);
			logic [TIME_W-1:0] life;
			answer_t a;
			int pick;
			bit have;
			life = (c.kind == KIND_CLEAR_ALL) ? dur_long : dur_normal;
			pick = 0;
			have = 0;
			a = '0;
			case (c.op)
				OP_EMIT: begin
					for (int i = 0; i < SLOTS; i++) begin
						if (time_left[i] != 0 && entry_kind[i] == c.kind &&
						    entry_class[i] == c.cls && entry_ident[i] == c.ident) begin
							time_left[i] = life;
							return;
						end
						// first free slot ends the scan, later duplicates go unseen
						if (time_left[i] == 0) begin
							pick = i;
							have = 1;
							break;
						end
						if (!have || time_left[i] < time_left[pick]) begin
							pick = i;
							have = 1;
						end
					end
					if (have) begin
						entry_kind[pick]  = c.kind;
						entry_class[pick] = c.cls;
						entry_ident[pick] = c.ident;
						time_left[pick]   = life;
					end
				end
				OP_TICK: begin
					for (int i = 0; i < SLOTS; i++) begin
						time_left[i] = (time_left[i] > c.elapsed) ? time_left[i] - c.elapsed : '0;
					end
				end
				OP_QUERY: begin
					for (int i = 0; i < SLOTS; i++) begin
						// negative stored id is a wildcard
						if (!a.found && time_left[i] != 0 && entry_class[i] == c.cls &&
						    (entry_ident[i][IDENT_W-1] || entry_ident[i] == c.ident)) begin
							a.found = 1'b1;
							a.kind  = entry_kind[i];
						end
					end
					pending_answers.push_back(a);
				end
				default: begin
				end
			endcase
		endfunction

		function bit check_answer(answer_t got, output string why);
			answer_t want;
			why = "";
			if (pending_answers.size() == 0) begin
				why = $sformatf("answer found=%0d kind=%0d with nothing outstanding",
					got.found, got.kind);
				return 1;
			end
			want = pending_answers.pop_front();
			if (got.found != want.found) begin
				why = $sformatf("found %0d, predicted %0d", got.found, want.found);
			end
			if (got.kind != want.kind) begin
				why = {why, $sformatf(" found_kind %0d, predicted %0d", got.kind, want.kind)};
			end
			return why != "";
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [FUNC_W-1:0]    s_tuser   = OP_NONE;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TIME_W-1:0]    cfg_data  = '0;

	slot_table_scoreboard sb;
	int  mismatches   = 0;
	int  quiet_cycles = 0;
	int  src_pct      = 0;
	int  snk_pct      = 0;
	int  cur_normal   = DUR_NORMAL_RST;
	logic hold_off    = 1'b0;
	int  op_count [4] = '{0, 0, 0, 0};
	int  answers      = 0;
	int  hits         = 0;

	int ph_normal [PHASES] = '{300, 20, 0, 65535, 1, 40, 12};
	int ph_long   [PHASES] = '{1000, 60, 0, 65535, 65535, 7, 100};
	int ph_src    [PHASES] = '{0, 63, 0, 10, 63, 0, 10};
	int ph_snk    [PHASES] = '{0, 0, 63, 10, 0, 63, 10};
	int ph_items  [PHASES] = '{120, 110, 60, 120, 120, 120, 90};

	timed_slot_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatches++;
		// keep the log readable if everything goes wrong
		if (mismatches <= REPORT_CAP) begin
			$display("[%0t] mismatch: %s", $realtime, what);
		end
	endtask

	always @(posedge clk) begin
		m_tready <= !hold_off && ($urandom_range(99) >= snk_pct);
	end

	always @(posedge clk) begin
		string why;
		command_t c;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				answers++;
				if (m_tuser) begin
					hits++;
				end
				if (sb.check_answer({m_tuser, m_tdata[KIND_W-1:0]}, why)) begin
					report_mismatch(why);
				end
			end
			if (s_tvalid && s_tready) begin
				c.op      = s_tuser;
				c.kind    = s_tdata[2:0];
				c.cls     = s_tdata[6:3];
				c.ident   = s_tdata[14:7];
				c.elapsed = s_tdata[30:15];
				sb.note_command(c);
				op_count[s_tuser]++;
			end
			if (cfg_valid && cfg_ready) begin
				sb.write_register(cfg_index, cfg_data);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic command_t make_command(logic [FUNC_W-1:0] op, logic [KIND_W-1:0] kind,
		logic [CLASS_W-1:0] cls, logic signed [IDENT_W-1:0] ident, logic [TIME_W-1:0] elapsed);
		command_t c;
		c.op      = op;
		c.kind    = kind;
		c.cls     = cls;
		c.ident   = ident;
		c.elapsed = elapsed;
		return c;
	endfunction

	function automatic command_t random_command();
		command_t c;
		int r;
		r = $urandom_range(99);
		c.op = (r < 40) ? OP_EMIT : (r < 60) ? OP_TICK : (r < 96) ? OP_QUERY : OP_NONE;
		c.kind = ($urandom_range(9) == 0) ? KIND_W'($urandom_range(7)) : KIND_W'($urandom_range(4));
		// a narrow class pool makes restarts, evictions and query hits common
		c.cls = ($urandom_range(7) == 0) ? CLASS_W'($urandom_range(15)) : CLASS_W'($urandom_range(2));
		case ($urandom_range(7))
			0: c.ident = -8'sd1;
			1: c.ident = -8'sd128;
			2: c.ident = 8'sd0;
			3: c.ident = 8'sd1;
			4: c.ident = 8'sd127;
			5: c.ident = 8'sd2;
			default: c.ident = IDENT_W'($urandom_range(255));
		endcase
		case ($urandom_range(7))
			0: c.elapsed = '0;
			1: c.elapsed = TIME_W'($urandom_range(65535));
			2: c.elapsed = '1;
			default: c.elapsed = TIME_W'($urandom_range(cur_normal / 4 + 1));
		endcase
		return c;
	endfunction

	task automatic send_command(input command_t c);
		while ($urandom_range(99) < src_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.op;
		s_tdata  <= {1'b0, c.elapsed, c.ident, c.cls, c.kind};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic write_duration_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// emits and ticks give no answer, so allow the scan to finish after the last one
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		command_t directed[$];
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed sequence under reset durations
		directed.push_back(make_command(OP_QUERY, 3'd0, 4'd0, 8'sd0, 16'd0));
		directed.push_back(make_command(OP_EMIT, 3'd0, 4'd15, 8'sd127, 16'hFFFF));
		directed.push_back(make_command(OP_EMIT, 3'd1, 4'd0, -8'sd128, 16'd0));
		directed.push_back(make_command(OP_EMIT, KIND_CLEAR_ALL, 4'd3, 8'sd0, 16'd0));
		directed.push_back(make_command(OP_EMIT, 3'd4, 4'd3, 8'sd0, 16'd0));
		directed.push_back(make_command(OP_QUERY, 3'd0, 4'd0, 8'sd55, 16'd0));
		directed.push_back(make_command(OP_QUERY, 3'd0, 4'd15, 8'sd127, 16'd0));
		directed.push_back(make_command(OP_QUERY, 3'd0, 4'd15, -8'sd1, 16'd0));
		// table full: evicts the earliest of the shortest timers
		directed.push_back(make_command(OP_EMIT, 3'd7, 4'd9, 8'sd9, 16'd0));
		directed.push_back(make_command(OP_EMIT, 3'd1, 4'd0, -8'sd128, 16'd0));
		directed.push_back(make_command(OP_TICK, 3'd0, 4'd0, 8'sd0, 16'd299));
		directed.push_back(make_command(OP_QUERY, 3'd0, 4'd9, 8'sd9, 16'd0));
		directed.push_back(make_command(OP_TICK, 3'd0, 4'd0, 8'sd0, 16'd1));
		directed.push_back(make_command(OP_QUERY, 3'd0, 4'd9, 8'sd9, 16'd0));
		directed.push_back(make_command(OP_TICK, 3'd0, 4'd0, 8'sd0, 16'd0));
		directed.push_back(make_command(OP_NONE, 3'd7, 4'd15, -8'sd1, 16'hFFFF));
		directed.push_back(make_command(OP_TICK, 3'd0, 4'd0, 8'sd0, 16'hFFFF));
		directed.push_back(make_command(OP_QUERY, 3'd0, 4'd3, 8'sd0, 16'd0));
		// free slot ahead of a live duplicate takes the entry
		directed.push_back(make_command(OP_EMIT, 3'd0, 4'd5, 8'sd5, 16'd0));
		directed.push_back(make_command(OP_EMIT, KIND_CLEAR_ALL, 4'd6, -8'sd2, 16'd0));
		directed.push_back(make_command(OP_TICK, 3'd0, 4'd0, 8'sd0, 16'd300));
		directed.push_back(make_command(OP_EMIT, KIND_CLEAR_ALL, 4'd6, -8'sd2, 16'd0));
		directed.push_back(make_command(OP_QUERY, 3'd0, 4'd6, 8'sd100, 16'd0));
		directed.push_back(make_command(OP_QUERY, 3'd0, 4'd5, 8'sd5, 16'd0));
		foreach (directed[i]) begin
			send_command(directed[i]);
		end
		settle();

		for (int p = 0; p < PHASES; p++) begin
			write_duration_reg(REG_DUR_NORMAL, TIME_W'(ph_normal[p]));
			write_duration_reg(REG_DUR_LONG, TIME_W'(ph_long[p]));
			if (p == 2) begin
				// spare indexes must not disturb the durations
				write_duration_reg(REG_SPARE_2, 16'hFFFF);
				write_duration_reg(REG_SPARE_3, 16'h5A5A);
			end
			cur_normal = ph_normal[p];
			src_pct    = ph_src[p];
			snk_pct    = ph_snk[p];
			repeat (ph_items[p]) begin
				send_command(random_command());
			end
			if (p == PHASES - 1) begin
				// long receiver hold-off while queries keep coming, backing up the input
				src_pct = 0;
				fork
					begin
						hold_off <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_off <= 1'b0;
					end
					repeat (60) begin
						send_command(make_command(OP_QUERY, 3'd0, CLASS_W'($urandom_range(2)),
							IDENT_W'($urandom_range(255)), 16'd0));
					end
				join
			end
			settle();
		end

		$display("covered %0d commands: %0d emit, %0d tick, %0d query, %0d unused func",
			op_count[OP_EMIT] + op_count[OP_TICK] + op_count[OP_QUERY] + op_count[OP_NONE],
			op_count[OP_EMIT], op_count[OP_TICK], op_count[OP_QUERY], op_count[OP_NONE]);
		$display("%0d answers checked (%0d hits) over %0d duration settings and four idle modes",
			answers, hits, PHASES + 1);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
